@@ hw/rtl/pbd_pkg.sv @@
`default_nettype none

package pbd_pkg;

	localparam int MAX_ITEMS = 32;
	localparam int DEPTH     = MAX_ITEMS + 1;
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int ITEM_W    = $clog2(MAX_ITEMS + 1);
	localparam int CFG_W     = 6;
	localparam int DIST_W    = 25;
	localparam int PROB_W    = 17;
	localparam int FRAC_P    = 16;
	localparam int PROD_W    = DIST_W + PROB_W;
	localparam int TERM_W    = PROD_W - FRAC_P;
	localparam int SUM_W     = TERM_W + 1;
	localparam int ACC_W     = DIST_W + $clog2(DEPTH);

	localparam logic [DIST_W-1:0] ONE_Q24 = DIST_W'(1) << 24;
	localparam logic [PROB_W-1:0] ONE_Q16 = PROB_W'(1) << FRAC_P;
	localparam logic [CFG_W-1:0]  MIN_SUPPORT_RST = CFG_W'(1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN
	} pbd_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/pbd_ram.sv @@
`default_nettype none

module pbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/poisson_binomial_pdf_update.sv @@
`default_nettype none

// Poisson-binomial distribution updater. Each transfer on start/prob/first folds one
// Bernoulli item into a distribution of MAX_ITEMS+1 Q1.24 entries held in one RAM (an
// item beyond MAX_ITEMS is dropped and sets the overflow flag), and once the last entry
// has been summed, done pulses for a single cycle with P(count < min_support), the item
// count and the sticky overflow flag. The update is a read-modify-write sweep over every
// RAM entry, one entry per cycle through a read, multiply, write-back and sum stage. busy
// is high from the transfer until the cycle of done, so one item is in flight at a time;
// a new start may come in the done cycle itself.
// The receiver cannot stall: done must be taken when it shows.
// The RAM needs no clearing pass after reset, since per-entry valid bits stand in for it.
module poisson_binomial_pdf_update (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [pbd_pkg::PROB_W-1:0]   prob,
	input  wire logic                         first,
	output logic                              done,
	output logic      [pbd_pkg::DIST_W-1:0]   below_support,
	output logic      [pbd_pkg::ITEM_W-1:0]   item_count,
	output logic                              overflowed,
	input  wire logic                         cfg_we,
	input  wire logic [pbd_pkg::CFG_W-1:0]    cfg_wdata
);

	import pbd_pkg::*;

	localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(DEPTH - 1);
	localparam logic [ITEM_W-1:0] MAX_CNT  = ITEM_W'(MAX_ITEMS);

	pbd_state_t state_q, state_d;

	logic                  accept;
	logic                  rd_en;
	logic [CFG_W-1:0]      min_support_q;
	logic [ITEM_W-1:0]     items_seen_q;
	logic                  ovf_q;
	logic [PROB_W-1:0]     p_q, q_q;
	logic [IDX_W-1:0]      rd_idx_q;
	logic [DEPTH-1:0]      ent_vld_q;

	logic                  vld_s1, ent_vld_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic [DIST_W-1:0]     rdata;
	logic [DIST_W-1:0]     old_s1;
	logic [DIST_W-1:0]     prev_q;

	logic                  vld_s2;
	logic [IDX_W-1:0]      idx_s2;
	logic [PROD_W-1:0]     prod_lo_s2, prod_hi_s2;
	logic [SUM_W-1:0]      sum_s2;
	logic [DIST_W-1:0]     new_s2;

	logic                  vld_s3;
	logic [IDX_W-1:0]      idx_s3;
	logic [DIST_W-1:0]     new_s3;
	logic                  in_sum_s3;
	logic                  last_s3;
	logic [ACC_W-1:0]      acc_q, acc_next;

	logic [PROB_W-1:0]     p_sat;
	logic [ITEM_W-1:0]     items_eff;
	logic                  apply;

	assign accept = start && !busy;

	// Restart takes effect before the capacity check of the same item.
	assign p_sat     = (prob > ONE_Q16) ? ONE_Q16 : prob;
	assign items_eff = first ? '0 : items_seen_q;
	assign apply     = items_eff < MAX_CNT;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (rd_idx_q == LAST_IDX) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (last_s3) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy  = 1'b1;
		rd_en = 1'b0;
		unique case (state_q)
			ST_IDLE:  busy  = 1'b0;
			ST_SWEEP: rd_en = 1'b1;
			ST_DRAIN: rd_en = 1'b0;
			default: begin
				busy  = 1'b1;
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			min_support_q <= MIN_SUPPORT_RST;
			items_seen_q  <= '0;
			ovf_q         <= 1'b0;
			rd_idx_q      <= '0;
			ent_vld_q     <= '0;
			vld_s1        <= 1'b0;
			vld_s2        <= 1'b0;
			vld_s3        <= 1'b0;
			done          <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= rd_en;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			done    <= last_s3;
			if (cfg_we) begin
				min_support_q <= cfg_wdata;
			end
			if (accept) begin
				rd_idx_q <= '0;
				if (first) begin
					ovf_q     <= 1'b0;
					ent_vld_q <= '0;
				end
				if (apply) begin
					items_seen_q <= items_eff + ITEM_W'(1);
				end else begin
					items_seen_q <= items_eff;
					ovf_q        <= 1'b1;
				end
			end else if (rd_en) begin
				rd_idx_q <= rd_idx_q + IDX_W'(1);
			end
			if (vld_s2) begin
				ent_vld_q[idx_s2] <= 1'b1;
			end
		end
	end

	// A dropped item still sweeps the store with p = 0, which writes every entry back
	// unchanged and leaves the sum path the same as for an applied item.
	always_ff @(posedge clk) begin
		if (accept) begin
			p_q    <= apply ? p_sat : '0;
			q_q    <= apply ? (ONE_Q16 - p_sat) : ONE_Q16;
			prev_q <= '0;
			acc_q  <= '0;
		end else begin
			if (vld_s1) begin
				prev_q <= old_s1;
			end
			if (vld_s3) begin
				acc_q <= acc_next;
			end
		end
		idx_s1     <= rd_idx_q;
		ent_vld_s1 <= ent_vld_q[rd_idx_q];
		idx_s2     <= idx_s1;
		prod_lo_s2 <= PROD_W'(prev_q) * PROD_W'(p_q);
		prod_hi_s2 <= PROD_W'(old_s1) * PROD_W'(q_q);
		idx_s3     <= idx_s2;
		new_s3     <= new_s2;
		if (last_s3) begin
			below_support <= (acc_next > ACC_W'(ONE_Q24)) ? ONE_Q24 : acc_next[DIST_W-1:0];
		end
	end

	pbd_ram #(
		.WIDTH(DIST_W),
		.DEPTH(DEPTH)
	) u_dist_ram (
		.clk  (clk),
		.we   (vld_s2),
		.waddr(idx_s2),
		.wdata(new_s2),
		.re   (rd_en),
		.raddr(rd_idx_q),
		.rdata(rdata)
	);

	// An entry not written since reset or restart holds its reset value.
	always_comb begin
		if (ent_vld_s1) begin
			old_s1 = rdata;
		end else if (idx_s1 == '0) begin
			old_s1 = ONE_Q24;
		end else begin
			old_s1 = '0;
		end
	end

	assign sum_s2 = SUM_W'(prod_lo_s2[PROD_W-1:FRAC_P]) + SUM_W'(prod_hi_s2[PROD_W-1:FRAC_P]);
	assign new_s2 = (sum_s2 > SUM_W'(ONE_Q24)) ? ONE_Q24 : sum_s2[DIST_W-1:0];

	assign in_sum_s3 = int'(idx_s3) < int'(min_support_q);
	assign acc_next  = acc_q + (in_sum_s3 ? ACC_W'(new_s3) : '0);
	assign last_s3   = vld_s3 && (idx_s3 == LAST_IDX);

	assign item_count = items_seen_q;
	assign overflowed = ovf_q;

endmodule

`default_nettype wire

@@ hw/rtl/pbd_checker.sv @@
`default_nettype none

module pbd_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       start,
	input wire logic                       busy,
	input wire logic                       done,
	input wire logic [pbd_pkg::DIST_W-1:0] below_support,
	input wire logic [pbd_pkg::ITEM_W-1:0] item_count
);

	import pbd_pkg::*;

	// A transfer always leads into the busy phase.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	// A result only ends a busy phase.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("done without a preceding busy phase");

	a_sum_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> below_support <= ONE_Q24)
		else $error("below_support above 1.0");

	a_count_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> int'(item_count) <= MAX_ITEMS)
		else $error("item_count beyond capacity");

endmodule

bind poisson_binomial_pdf_update pbd_checker u_pbd_checker (.*);

`default_nettype wire
